// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge, quiet while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on the rising edge, quiet while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mse_pkg.sv -----
package mse_pkg;

    // major opcodes
    localparam logic [5:0] OPC_RTYPE = 6'h00;
    localparam logic [5:0] OPC_BEQ   = 6'h04;
    localparam logic [5:0] OPC_ADDI  = 6'h08;
    localparam logic [5:0] OPC_ORI   = 6'h0D;
    localparam logic [5:0] OPC_LUI   = 6'h0F;
    localparam logic [5:0] OPC_LW    = 6'h23;
    localparam logic [5:0] OPC_SW    = 6'h2B;

    // r-type function codes
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_SLT     = 6'h2A;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_DEST = 2'd1;
    localparam logic [1:0] ST_BAD_OP    = 2'd2;

    typedef enum logic [3:0] {
        OP_ADDI,
        OP_LUI,
        OP_ORI,
        OP_LW,
        OP_SW,
        OP_BEQ,
        OP_ADD,
        OP_AND,
        OP_SLT,
        OP_SYS,
        OP_BAD
    } op_kind_t;

    // classified instruction, as held in the queue
    typedef struct packed {
        op_kind_t    kind;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  dest;
        logic        wr;
        logic        use_rs;
        logic        use_rt;
        logic [15:0] imm;
    } dec_t;

    // one slot of the execute pipeline
    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic        halted;
        logic [31:0] pc;
        logic [4:0]  dest;
        logic        wr;
        logic        load;
        logic        store;
        logic [31:0] value;
    } pipe_t;

endpackage

// ----- rtl/mse_front.sv -----
module mse_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [31:0]    instruction_word,
    input  logic           hold,
    output logic           head_valid,
    output mse_pkg::dec_t  head,
    input  logic           pop
);
    import mse_pkg::*;

    localparam int Q_DEPTH = 2;
    localparam int PW = $clog2(Q_DEPTH);

    dec_t                 dec;
    dec_t                 q_mem [Q_DEPTH];
    logic [PW-1:0]        wr_ptr_reg;
    logic [PW-1:0]        rd_ptr_reg;
    logic [PW:0]          count_reg;
    logic                 push;

    // classify the raw word
    always_comb
    begin
        dec.rs     = instruction_word[25:21];
        dec.rt     = instruction_word[20:16];
        dec.imm    = instruction_word[15:0];
        dec.kind   = OP_BAD;
        dec.dest   = 5'd0;
        dec.wr     = 1'b0;
        dec.use_rs = 1'b0;
        dec.use_rt = 1'b0;
        unique case (instruction_word[31:26])
            OPC_ADDI: dec.kind = OP_ADDI;
            OPC_LUI:  dec.kind = OP_LUI;
            OPC_ORI:  dec.kind = OP_ORI;
            OPC_LW:   dec.kind = OP_LW;
            OPC_SW:   dec.kind = OP_SW;
            OPC_BEQ:  dec.kind = OP_BEQ;
            OPC_RTYPE:
            begin
                unique case (instruction_word[5:0])
                    FN_ADD:     dec.kind = OP_ADD;
                    FN_AND:     dec.kind = OP_AND;
                    FN_SLT:     dec.kind = OP_SLT;
                    FN_SYSCALL: dec.kind = OP_SYS;
                    default:    dec.kind = OP_BAD;
                endcase
            end
            default: dec.kind = OP_BAD;
        endcase

        unique case (dec.kind) inside
            OP_ADDI, OP_ORI, OP_LW:
            begin
                dec.dest   = instruction_word[20:16];
                dec.wr     = 1'b1;
                dec.use_rs = 1'b1;
            end
            OP_LUI:
            begin
                dec.dest = instruction_word[20:16];
                dec.wr   = 1'b1;
            end
            OP_ADD, OP_AND, OP_SLT:
            begin
                dec.dest   = instruction_word[15:11];
                dec.wr     = 1'b1;
                dec.use_rs = 1'b1;
                dec.use_rt = 1'b1;
            end
            OP_SW, OP_BEQ:
            begin
                dec.use_rs = 1'b1;
                dec.use_rt = 1'b1;
            end
            default:
            begin
                dec.wr = 1'b0;
            end
        endcase
    end

    // short queue toward the execute side
    assign in_ready   = (count_reg != (PW+1)'(Q_DEPTH)) && !hold;
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != '0);
    assign head       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/mse_wordidx.sv -----
module mse_wordidx #(
    parameter int unsigned DMEM_WORDS = 1024
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [31:0]                   sum,
    output logic [$clog2(DMEM_WORDS)-1:0] idx
);
    // sum mod DMEM_WORDS by exact reciprocal multiply, three register levels
    localparam int L  = $clog2(DMEM_WORDS);
    localparam int QW = 33 - L;
    localparam logic [63:0] RECIP = ((64'd1 << (32 + L)) / 64'(DMEM_WORDS)) + 64'd1;

    logic [31:0]   sum_a_reg;
    logic [31:0]   sum_b_reg;
    logic [QW-1:0] q_reg;
    logic [L-1:0]  idx_reg;
    logic [64:0]   prod;
    logic [31:0]   qd;
    logic [31:0]   rem;

    assign prod = {33'd0, sum_a_reg} * {32'd0, RECIP[32:0]};
    assign qd   = 32'(q_reg) * 32'(DMEM_WORDS);
    assign rem  = sum_b_reg - qd;
    assign idx  = idx_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_a_reg <= sum;
            sum_b_reg <= sum_a_reg;
            q_reg     <= prod[32+L +: QW];
            idx_reg   <= rem[L-1:0];
        end
    end

endmodule

// ----- rtl/mse_back.sv -----
module mse_back #(
    parameter int unsigned DMEM_WORDS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  mse_pkg::dec_t       head,
    output logic                pop,
    output logic                busy,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic                halted_flag,
    output logic [31:0]         pc_now,
    output logic [4:0]          dest_index,
    output logic signed [31:0]  result_value,
    output logic                memory_written
);
    import mse_pkg::*;

    localparam int AW        = $clog2(DMEM_WORDS);
    localparam int CLR_WORDS = (DMEM_WORDS > 32) ? int'(DMEM_WORDS) : 32;
    localparam int CW        = $clog2(CLR_WORDS);

    // youngest matching producer wins; {wait_on_load, value}
    function automatic logic [32:0] fwd_sel(
        input logic [4:0]  r,
        input logic [31:0] base,
        input pipe_t       p3,
        input pipe_t       p4,
        input pipe_t       p5,
        input pipe_t       p6,
        input logic [31:0] v6
    );
        logic hit3;
        logic hit4;
        logic hit5;
        logic hit6;
        hit3 = p3.valid && p3.wr && (p3.dest == r);
        hit4 = p4.valid && p4.wr && (p4.dest == r);
        hit5 = p5.valid && p5.wr && (p5.dest == r);
        hit6 = p6.valid && p6.wr && (p6.dest == r);
        if (hit3)
            fwd_sel = {p3.load, p3.value};
        else if (hit4)
            fwd_sel = {p4.load, p4.value};
        else if (hit5)
            fwd_sel = {p5.load, p5.value};
        else if (hit6)
            fwd_sel = {1'b0, v6};
        else
            fwd_sel = {1'b0, base};
    endfunction

    logic [31:0]   rf_mem [32];
    logic [31:0]   dmem [DMEM_WORDS];

    logic          clr_busy_reg;
    logic [CW-1:0] clr_cnt_reg;

    logic          s2_valid_reg;
    dec_t          s2_reg;
    logic          s2_fresh_reg;
    logic [31:0]   rf_a_reg;
    logic [31:0]   rf_b_reg;
    logic [31:0]   a_hold_reg;
    logic [31:0]   b_hold_reg;
    logic [31:0]   pc_reg;
    logic          halt_reg;
    pipe_t         s3_reg;
    pipe_t         s4_reg;
    pipe_t         s5_reg;
    pipe_t         s6_reg;
    pipe_t         s3_next;
    logic [31:0]   dmem_rdata_reg;

    logic          move;
    logic          stall;
    logic          advance_s2;
    logic [31:0]   s6_result;
    logic [32:0]   fa_pick;
    logic [32:0]   fb_pick;
    logic [31:0]   fa;
    logic [31:0]   fb;
    logic [31:0]   sext;
    logic [31:0]   sum;
    logic [31:0]   alu_value;
    logic          taken;
    logic [31:0]   pc_next;
    logic          zero_dest;
    logic [AW-1:0] s5_idx;

    logic          rf_we;
    logic [4:0]    rf_waddr;
    logic [31:0]   rf_wdata;
    logic          dmem_we;
    logic [AW-1:0] dmem_waddr;
    logic [31:0]   dmem_wdata;

    assign busy      = clr_busy_reg;
    assign move      = !s6_reg.valid || out_ready;
    assign s6_result = s6_reg.load ? dmem_rdata_reg : s6_reg.value;

    // operand pick with forwarding
    assign fa_pick = fwd_sel(s2_reg.rs, s2_fresh_reg ? rf_a_reg : a_hold_reg,
                             s3_reg, s4_reg, s5_reg, s6_reg, s6_result);
    assign fb_pick = fwd_sel(s2_reg.rt, s2_fresh_reg ? rf_b_reg : b_hold_reg,
                             s3_reg, s4_reg, s5_reg, s6_reg, s6_result);
    assign fa      = fa_pick[31:0];
    assign fb      = fb_pick[31:0];

    assign stall = s2_valid_reg && !halt_reg &&
                   ((s2_reg.use_rs && fa_pick[32]) || (s2_reg.use_rt && fb_pick[32]));
    assign advance_s2 = move && s2_valid_reg && !stall;
    assign pop        = head_valid && !clr_busy_reg && (!s2_valid_reg || advance_s2);

    // execute
    always_comb
    begin
        sext    = {{16{s2_reg.imm[15]}}, s2_reg.imm};
        sum     = fa + ((s2_reg.kind == OP_ADD) ? fb : sext);
        taken   = (s2_reg.kind == OP_BEQ) && (fa == fb);
        pc_next = pc_reg + 32'd4 + (taken ? {sext[29:0], 2'b00} : 32'd0);
        zero_dest = s2_reg.wr && (s2_reg.dest == 5'd0);

        unique case (s2_reg.kind) inside
            OP_ADDI, OP_ADD: alu_value = sum;
            OP_LUI:          alu_value = {s2_reg.imm, 16'h0000};
            OP_ORI:          alu_value = fa | {16'h0000, s2_reg.imm};
            OP_AND:          alu_value = fa & fb;
            OP_SLT:          alu_value = {31'd0, ($signed(fa) < $signed(fb))};
            OP_SW:           alu_value = fb;
            default:         alu_value = 32'd0;
        endcase

        s3_next       = '0;
        s3_next.valid = advance_s2;
        if (halt_reg)
        begin
            s3_next.status = ST_OK;
            s3_next.halted = 1'b1;
            s3_next.pc     = pc_reg;
        end
        else
        begin
            s3_next.halted = (s2_reg.kind == OP_SYS);
            s3_next.pc     = pc_next;
            if (s2_reg.kind == OP_BAD)
            begin
                s3_next.status = ST_BAD_OP;
            end
            else if (zero_dest)
            begin
                s3_next.status = ST_ZERO_DEST;
            end
            else
            begin
                s3_next.status = ST_OK;
                s3_next.wr     = s2_reg.wr;
                s3_next.dest   = s2_reg.dest;
                s3_next.value  = alu_value;
                s3_next.load   = (s2_reg.kind == OP_LW);
                s3_next.store  = (s2_reg.kind == OP_SW);
            end
        end
    end

    // word index runs alongside stages 3 to 5
    mse_wordidx #(
        .DMEM_WORDS (DMEM_WORDS)
    ) u_wordidx (
        .clk (clk),
        .en  (move),
        .sum (sum),
        .idx (s5_idx)
    );

    // register file port: clearing pass, else retire from stage 6
    always_comb
    begin
        if (clr_busy_reg)
        begin
            rf_we    = 1'b1;
            rf_waddr = clr_cnt_reg[4:0];
            rf_wdata = 32'd0;
        end
        else
        begin
            rf_we    = move && s6_reg.valid && s6_reg.wr;
            rf_waddr = s6_reg.dest;
            rf_wdata = s6_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        if (pop)
        begin
            rf_a_reg <= (rf_we && (rf_waddr == head.rs)) ? rf_wdata : rf_mem[head.rs];
            rf_b_reg <= (rf_we && (rf_waddr == head.rt)) ? rf_wdata : rf_mem[head.rt];
        end
    end

    // data memory port
    always_comb
    begin
        if (clr_busy_reg)
        begin
            dmem_we    = ({1'b0, clr_cnt_reg} < (CW+1)'(DMEM_WORDS));
            dmem_waddr = clr_cnt_reg[AW-1:0];
            dmem_wdata = 32'd0;
        end
        else
        begin
            dmem_we    = move && s5_reg.valid && s5_reg.store;
            dmem_waddr = s5_idx;
            dmem_wdata = s5_reg.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dmem_we)
        begin
            dmem[dmem_waddr] <= dmem_wdata;
        end
        if (move)
        begin
            dmem_rdata_reg <= dmem[s5_idx];
        end
    end

    // operand hold while waiting in stage 2
    always_ff @(posedge clk)
    begin
        a_hold_reg <= fa;
        b_hold_reg <= fb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_cnt_reg == CW'(CLR_WORDS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_reg       <= '0;
            s2_fresh_reg <= 1'b0;
            pc_reg       <= 32'd0;
            halt_reg     <= 1'b0;
            s3_reg       <= '0;
            s4_reg       <= '0;
            s5_reg       <= '0;
            s6_reg       <= '0;
        end
        else
        begin
            s2_fresh_reg <= pop;
            if (pop)
            begin
                s2_valid_reg <= 1'b1;
                s2_reg       <= head;
            end
            else if (advance_s2)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (advance_s2 && !halt_reg)
            begin
                pc_reg   <= pc_next;
                halt_reg <= (s2_reg.kind == OP_SYS);
            end

            if (move)
            begin
                s3_reg <= s3_next;
                s4_reg <= s3_reg;
                s5_reg <= s4_reg;
                s6_reg <= s5_reg;
            end
        end
    end

    assign out_valid      = s6_reg.valid;
    assign status         = s6_reg.status;
    assign halted_flag    = s6_reg.halted;
    assign pc_now         = s6_reg.pc;
    assign dest_index     = s6_reg.dest;
    assign result_value   = $signed(s6_result);
    assign memory_written = s6_reg.store;

endmodule

// ----- rtl/mips_subset_execute.sv -----
// an accepted instruction passes through the queue and stages 2 to 6 before its result is valid
// throughput: one instruction per cycle unless the output stalls; a use of a load
//   result by one of the next three instructions waits for the data memory read
// reset: rst_n clears pc, halt and pipeline at once, then a clearing pass zeroes
//   data memory and register file, with in_ready low
module mips_subset_execute #(
    parameter int unsigned DMEM_WORDS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        instruction_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic               halted_flag,
    output logic [31:0]        pc_now,
    output logic [4:0]         dest_index,
    output logic signed [31:0] result_value,
    output logic               memory_written
);
    import mse_pkg::*;

    // front side: decode each item into an operation class and its register
    // fields, then park it in a two-entry queue so the input keeps flowing, until the
    // queue is full, while the execute side waits on a hazard or on the output
    dec_t q_head;
    logic q_head_valid;
    logic q_pop;
    logic clearing;

    mse_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .instruction_word (instruction_word),
        .hold             (clearing),
        .head_valid       (q_head_valid),
        .head             (q_head),
        .pop              (q_pop)
    );

    // back side: execute pipeline
    //   stage 2 reads operands (forwarded from later stages), runs the alu,
    //     resolves branches, and updates pc and halt
    //   stages 3 and 4 turn the load/store address into a word index
    //     (reciprocal multiply, then multiply-subtract)
    //   stage 5 reads or writes the data memory
    //   stage 6 is the output register; the register file is written when
    //     the item leaves it
    mse_back #(
        .DMEM_WORDS (DMEM_WORDS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (q_head_valid),
        .head           (q_head),
        .pop            (q_pop),
        .busy           (clearing),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .halted_flag    (halted_flag),
        .pc_now         (pc_now),
        .dest_index     (dest_index),
        .result_value   (result_value),
        .memory_written (memory_written)
    );

endmodule

// ----- rtl/mse_checker.sv -----
`include "assert_macros.svh"

module mse_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         status,
    input logic               halted_flag,
    input logic [31:0]        pc_now,
    input logic [4:0]         dest_index,
    input logic signed [31:0] result_value,
    input logic               memory_written
);
    import mse_pkg::*;

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pc_now) && $stable(result_value) && $stable(status) && $stable(dest_index), "stalled result changed")

    // rejected or unknown items write nothing
    `ASSERT_IMPLIES(a_err_quiet, clk, rst_n, out_valid && (status != ST_OK), (dest_index == 5'd0) && !memory_written && (result_value == 32'sd0), "error item wrote")

    // once halted, items have no effect
    `ASSERT_IMPLIES(a_halt_quiet, clk, rst_n, out_valid && halted_flag, (status == ST_OK) && (dest_index == 5'd0) && !memory_written && (result_value == 32'sd0), "halted item wrote")

    // a store never also writes a register
    `ASSERT_IMPLIES(a_store_only, clk, rst_n, out_valid && memory_written, (dest_index == 5'd0) && (status == ST_OK) && !halted_flag, "store with register write")

endmodule

bind mips_subset_execute mse_checker u_mse_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .halted_flag    (halted_flag),
    .pc_now         (pc_now),
    .dest_index     (dest_index),
    .result_value   (result_value),
    .memory_written (memory_written)
);
